// ===== design/smoothed_mixed_wave_lfo_macros.svh =====
// Assertion macros used by the checker of the smoothed mixed-wave LFO.
`ifndef SMOOTHED_MIXED_WAVE_LFO_MACROS_SVH
`define SMOOTHED_MIXED_WAVE_LFO_MACROS_SVH

// Same-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define SMWLFO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define SMWLFO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/smwlfo_pkg.sv =====
// Types, constants, sine table builder and microprogram of the smoothed mixed-wave LFO.
package smwlfo_pkg;

  // Register indexes on the config port
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_US   = 1'b1;

  localparam int CFG_DATA_W = 32;
  localparam int PHASE_W    = 32;
  localparam int DEPTH_W    = 18;

  localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 32'd97392;
  localparam logic [DEPTH_W-1:0] DEPTH_US_RST   = 18'd0;

  // Mix and smoothing weights, Q0.16
  localparam logic [15:0] K_SIN = 16'd58982;
  localparam logic [15:0] K_TRI = 16'd6554;
  localparam logic [15:0] K_OLD = 16'd64881;
  localparam logic [15:0] K_NEW = 16'd655;

  // Odd polynomial for the quarter-wave sine, Q30
  localparam longint Q30_ONE = longint'(1) << 30;
  localparam longint COEF0 = 64'sd1686629713;
  localparam longint COEF1 = 64'sd693598668;
  localparam longint COEF2 = 64'sd85569306;
  localparam longint COEF3 = 64'sd5026995;
  localparam longint COEF4 = 64'sd172272;
  localparam longint COEF5 = 64'sd3864;

  // Table entry k for 2^tb steps per quarter turn, returned in Q.f.
  // Only ever called with constant arguments.
  function automatic longint sine_entry(input int k, input int tb, input int f);
    longint x;
    longint x2;
    longint p;
    x  = longint'(k) <<< (30 - tb);
    x2 = (x * x) / Q30_ONE;
    p  = -COEF5;
    p  = COEF4 + (p * x2) / Q30_ONE;
    p  = -COEF3 + (p * x2) / Q30_ONE;
    p  = COEF2 + (p * x2) / Q30_ONE;
    p  = -COEF1 + (p * x2) / Q30_ONE;
    p  = COEF0 + (p * x2) / Q30_ONE;
    p  = (p * x) / Q30_ONE;
    if (p < 0) begin
      p = 0;
    end
    if (p > Q30_ONE) begin
      p = Q30_ONE;
    end
    if (f < 30) begin
      p = (p + (longint'(1) <<< (29 - f))) >>> (30 - f);
    end
    return p;
  endfunction

  // Microprogram step codes
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_RD_A   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_RD_B   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_DIFF   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_M_FRAC = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SINE   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_M_SIN  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_M_TRI  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_MIX    = 4'd8;
  localparam logic [STEP_W-1:0] STEP_M_OLD  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_M_NEW  = 4'd10;
  localparam logic [STEP_W-1:0] STEP_SMOOTH = 4'd11;
  localparam logic [STEP_W-1:0] STEP_UNIT   = 4'd12;
  localparam logic [STEP_W-1:0] STEP_M_DEP  = 4'd13;
  localparam logic [STEP_W-1:0] STEP_EMIT   = 4'd14;

  // Jump conditions
  localparam logic [1:0] JC_ALWAYS   = 2'd0;
  localparam logic [1:0] JC_IN_ACC   = 2'd1;
  localparam logic [1:0] JC_OUT_FREE = 2'd2;

  // Multiplier A operand
  localparam logic [1:0] MA_DIF  = 2'd0;
  localparam logic [1:0] MA_WORK = 2'd1;
  localparam logic [1:0] MA_TRI  = 2'd2;
  localparam logic [1:0] MA_SM   = 2'd3;

  // Multiplier B operand
  localparam logic [2:0] MB_FRAC  = 3'd0;
  localparam logic [2:0] MB_K_SIN = 3'd1;
  localparam logic [2:0] MB_K_TRI = 3'd2;
  localparam logic [2:0] MB_K_OLD = 3'd3;
  localparam logic [2:0] MB_K_NEW = 3'd4;
  localparam logic [2:0] MB_DEPTH = 3'd5;

  // Work register loads
  localparam logic [1:0] WO_NONE = 2'd0;
  localparam logic [1:0] WO_SINE = 2'd1;
  localparam logic [1:0] WO_MIX  = 2'd2;
  localparam logic [1:0] WO_UNIT = 2'd3;

  typedef struct packed {
    logic              rom_rd;
    logic              rom_sel_b;
    logic              a_ld;
    logic              dif_ld;
    logic              mul_en;
    logic [1:0]        ma_sel;
    logic [2:0]        mb_sel;
    logic              acc_ld;
    logic [1:0]        w_op;
    logic              sm_ld;
    logic              out_ld;
    logic [1:0]        jc;
    logic [STEP_W-1:0] target;
  } ctl_t;

  // Control store: one word per step
  function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
    ctl_t c;
    c        = '0;
    c.jc     = JC_ALWAYS;
    c.target = STEP_IDLE;
    unique case (step)
      STEP_IDLE: begin
        c.jc     = JC_IN_ACC;
        c.target = STEP_RD_A;
      end
      STEP_RD_A: begin
        c.rom_rd = 1'b1;
        c.target = STEP_RD_B;
      end
      STEP_RD_B: begin
        c.a_ld      = 1'b1;
        c.rom_rd    = 1'b1;
        c.rom_sel_b = 1'b1;
        c.target    = STEP_DIFF;
      end
      STEP_DIFF: begin
        c.dif_ld = 1'b1;
        c.target = STEP_M_FRAC;
      end
      STEP_M_FRAC: begin
        c.mul_en = 1'b1;
        c.ma_sel = MA_DIF;
        c.mb_sel = MB_FRAC;
        c.target = STEP_SINE;
      end
      STEP_SINE: begin
        c.w_op   = WO_SINE;
        c.target = STEP_M_SIN;
      end
      STEP_M_SIN: begin
        c.mul_en = 1'b1;
        c.ma_sel = MA_WORK;
        c.mb_sel = MB_K_SIN;
        c.target = STEP_M_TRI;
      end
      STEP_M_TRI: begin
        c.acc_ld = 1'b1;
        c.mul_en = 1'b1;
        c.ma_sel = MA_TRI;
        c.mb_sel = MB_K_TRI;
        c.target = STEP_MIX;
      end
      STEP_MIX: begin
        c.w_op   = WO_MIX;
        c.target = STEP_M_OLD;
      end
      STEP_M_OLD: begin
        c.mul_en = 1'b1;
        c.ma_sel = MA_SM;
        c.mb_sel = MB_K_OLD;
        c.target = STEP_M_NEW;
      end
      STEP_M_NEW: begin
        c.acc_ld = 1'b1;
        c.mul_en = 1'b1;
        c.ma_sel = MA_WORK;
        c.mb_sel = MB_K_NEW;
        c.target = STEP_SMOOTH;
      end
      STEP_SMOOTH: begin
        c.sm_ld  = 1'b1;
        c.target = STEP_UNIT;
      end
      STEP_UNIT: begin
        c.w_op   = WO_UNIT;
        c.target = STEP_M_DEP;
      end
      STEP_M_DEP: begin
        c.mul_en = 1'b1;
        c.ma_sel = MA_WORK;
        c.mb_sel = MB_DEPTH;
        c.target = STEP_EMIT;
      end
      STEP_EMIT: begin
        c.out_ld = 1'b1;
        c.jc     = JC_OUT_FREE;
        c.target = STEP_IDLE;
      end
      default: begin
        c.target = STEP_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== design/smoothed_mixed_wave_lfo.sv =====
// Smoothed mixed-wave LFO: microcoded datapath producing one modulation word per tick.
//
// Input channel (in_valid_i/in_ready_o, restart_i): one word per tick. restart_i set
// clears the phase and the smoother before the sample is worked out.
// Output channel (out_valid_o/out_ready_i, lfo_us_o): one word per input word,
// 0..depth_us, held in an output register until taken.
// Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i): index 0 is
// phase_step (32 bit), index 1 is depth_us (low 18 bits of the data). Always ready;
// write only while no word is in flight.
// Sequencing: a 15-step control store drives one shared multiplier and one sine ROM
// read port. An accepted word runs through the steps in order up to the emit step;
// the next word is taken only once the sequencer is back at the idle step.
// If the output register is still full at the last step, the sequencer waits there
// and no new word is accepted until the receiver takes the old one.
// Reset: phase and smoother clear, phase_step returns to 97392, depth_us to 0,
// output empty. No clearing pass; the ROM is constant.
module smoothed_mixed_wave_lfo #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int WAVE_FRAC_BITS  = 22
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 restart_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [smwlfo_pkg::DEPTH_W-1:0]       lfo_us_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [smwlfo_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [smwlfo_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int TB    = SINE_TABLE_BITS;
  localparam int F     = WAVE_FRAC_BITS;
  localparam int N     = 1 << TB;          // quarter-wave steps
  localparam int FB    = 30 - TB;          // fraction bits of the table position
  localparam int IDX_W = TB + 1;
  localparam int TW    = F + 1;            // table entry, 0..2^F
  localparam int SW    = F + 2;            // signed wave / smoother
  localparam int MAW   = F + 3;            // multiplier A, signed
  localparam int MBW   = (FB > 18) ? FB : 18;
  localparam int PW    = MAW + MBW + 1;    // product
  localparam int DW    = smwlfo_pkg::DEPTH_W;
  localparam int PHW   = smwlfo_pkg::PHASE_W;

  localparam logic [PW-1:0]  FRAC_CEIL = PW'((64'd1 << FB) - 64'd1);
  localparam logic [PW:0]    HALF16    = (PW+1)'(1) << 15;
  localparam logic [SW:0]    UNIT_OFS  = (SW+1)'(1) << F;
  localparam logic [MAW-1:0] UNIT_MAX  = MAW'(1) << (F + 1);
  localparam logic [PW-1:0]  OUT_HALF  = PW'(1) << F;

  // sine ROM, built at elaboration
  logic [TW-1:0] sine_rom [N+1];
  for (genvar k = 0; k <= N; k++) begin : g_rom
    assign sine_rom[k] = TW'(smwlfo_pkg::sine_entry(k, TB, F));
  end

  logic [smwlfo_pkg::STEP_W-1:0] pc_q, pc_d;
  smwlfo_pkg::ctl_t              ctl;

  logic [PHW-1:0]        ph_q, ph_d;
  logic signed [SW-1:0]  sm_q, sm_d;
  logic [PHW-1:0]        step_q;
  logic [DW-1:0]         depth_q;
  logic                  out_valid_q, out_valid_d;
  logic [DW-1:0]         out_q;

  logic [TW-1:0]         rom_q;
  logic [TW-1:0]         a_q;
  logic [TW-1:0]         dif_q;
  logic                  neg_q;
  logic signed [MAW-1:0] w_q;
  logic signed [PW-1:0]  acc_q;
  logic signed [PW-1:0]  prod_q;

  logic                  in_acc;
  logic                  slot_free;
  logic                  emit;

  // phase decode
  logic [1:0]            quad;
  logic [30:0]           u_pos;
  logic [IDX_W-1:0]      idx, idx_b, rom_addr;
  logic [FB-1:0]         frac;
  logic [32:0]           tri_full;
  logic [F:0]            tri_w;

  // datapath
  logic signed [MAW-1:0] mul_a;
  logic [MBW-1:0]        mul_b;
  logic signed [PW-1:0]  mul_p;
  logic [PW-1:0]         t_full;
  logic [TW-1:0]         t_w, s_mag;
  logic signed [MAW-1:0] s_val;
  logic signed [PW:0]    rsum;
  logic signed [SW:0]    usum;
  logic [MAW-1:0]        unit_w;
  logic [PW-1:0]         out_rnd;
  logic [DW:0]           res_w;
  logic [DW-1:0]         res_sat;

  assign ctl         = smwlfo_pkg::ucode(pc_q);
  assign in_ready_o  = (pc_q == smwlfo_pkg::STEP_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign emit        = ctl.out_ld && slot_free;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign lfo_us_o    = out_q;

  // sequencer
  always_comb begin
    pc_d = pc_q;
    unique case (ctl.jc)
      smwlfo_pkg::JC_ALWAYS:   pc_d = ctl.target;
      smwlfo_pkg::JC_IN_ACC:   if (in_acc) pc_d = ctl.target;
      smwlfo_pkg::JC_OUT_FREE: if (slot_free) pc_d = ctl.target;
      default:                 pc_d = smwlfo_pkg::STEP_IDLE;
    endcase
  end

  // quadrant fold: odd quadrants run backwards through the table
  always_comb begin
    quad     = ph_q[31:30];
    u_pos    = quad[0] ? (31'h4000_0000 - {1'b0, ph_q[29:0]}) : {1'b0, ph_q[29:0]};
    idx      = u_pos[30:FB];
    frac     = u_pos[FB-1:0];
    idx_b    = (idx == IDX_W'(N)) ? idx : idx + 1'b1;
    rom_addr = ctl.rom_sel_b ? idx_b : idx;
    // triangle, mirrored about the half turn
    tri_full = ph_q[31] ? (33'h1_0000_0000 - {1'b0, ph_q}) : {1'b0, ph_q};
    tri_w    = tri_full[31:31-F];
  end

  // shared multiplier
  always_comb begin
    case (ctl.ma_sel)
      smwlfo_pkg::MA_DIF:  mul_a = $signed({2'b00, dif_q});
      smwlfo_pkg::MA_WORK: mul_a = w_q;
      smwlfo_pkg::MA_TRI:  mul_a = $signed({2'b00, tri_w});
      smwlfo_pkg::MA_SM:   mul_a = {sm_q[SW-1], sm_q};
      default:             mul_a = '0;
    endcase
    case (ctl.mb_sel)
      smwlfo_pkg::MB_FRAC:  mul_b = MBW'(frac);
      smwlfo_pkg::MB_K_SIN: mul_b = MBW'(smwlfo_pkg::K_SIN);
      smwlfo_pkg::MB_K_TRI: mul_b = MBW'(smwlfo_pkg::K_TRI);
      smwlfo_pkg::MB_K_OLD: mul_b = MBW'(smwlfo_pkg::K_OLD);
      smwlfo_pkg::MB_K_NEW: mul_b = MBW'(smwlfo_pkg::K_NEW);
      smwlfo_pkg::MB_DEPTH: mul_b = MBW'(depth_q);
      default:              mul_b = '0;
    endcase
    mul_p = mul_a * $signed({1'b0, mul_b});
  end

  always_comb begin
    // interpolation: floor going up, ceiling of the drop going down
    t_full = neg_q ? (($unsigned(prod_q) + FRAC_CEIL) >> FB) : ($unsigned(prod_q) >> FB);
    t_w    = t_full[TW-1:0];
    s_mag  = neg_q ? (a_q - t_w) : (a_q + t_w);
    s_val  = quad[1] ? -$signed({2'b00, s_mag}) : $signed({2'b00, s_mag});
    // acc + prod, rounded half up by 2^16
    rsum   = {acc_q[PW-1], acc_q} + {prod_q[PW-1], prod_q} + $signed(HALF16);
    // unit-range value, clamped to [0, 2^(F+1)]
    usum   = {sm_q[SW-1], sm_q} + $signed(UNIT_OFS);
    if (usum[SW]) begin
      unit_w = '0;
    end else if ($unsigned(usum) > UNIT_MAX) begin
      unit_w = UNIT_MAX;
    end else begin
      unit_w = $unsigned(usum);
    end
    out_rnd = $unsigned(prod_q) + OUT_HALF;
    res_w   = out_rnd[F+DW+1:F+1];
    res_sat = (res_w > {1'b0, depth_q}) ? depth_q : res_w[DW-1:0];
  end

  always_comb begin
    ph_d = ph_q;
    sm_d = sm_q;
    if (in_acc && restart_i) begin
      ph_d = '0;
      sm_d = '0;
    end
    if (ctl.sm_ld) begin
      sm_d = rsum[SW+15:16];
    end
    if (emit) begin
      ph_d = ph_q + step_q;   // wraps
    end
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= smwlfo_pkg::STEP_IDLE;
      ph_q        <= '0;
      sm_q        <= '0;
      out_valid_q <= 1'b0;
      step_q      <= smwlfo_pkg::PHASE_STEP_RST;
      depth_q     <= smwlfo_pkg::DEPTH_US_RST;
    end else begin
      pc_q        <= pc_d;
      ph_q        <= ph_d;
      sm_q        <= sm_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          smwlfo_pkg::REG_PHASE_STEP: step_q  <= cfg_data_i;
          smwlfo_pkg::REG_DEPTH_US:   depth_q <= cfg_data_i[DW-1:0];
          default: ;
        endcase
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (ctl.rom_rd) begin
      rom_q <= sine_rom[rom_addr];
    end
    if (ctl.a_ld) begin
      a_q <= rom_q;
    end
    if (ctl.dif_ld) begin
      neg_q <= (rom_q < a_q);
      dif_q <= (rom_q < a_q) ? (a_q - rom_q) : (rom_q - a_q);
    end
    if (ctl.mul_en) begin
      prod_q <= mul_p;
    end
    if (ctl.acc_ld) begin
      acc_q <= prod_q;
    end
    case (ctl.w_op)
      smwlfo_pkg::WO_SINE: w_q <= s_val;
      smwlfo_pkg::WO_MIX:  w_q <= {rsum[SW+15], rsum[SW+15:16]};
      smwlfo_pkg::WO_UNIT: w_q <= $signed(unit_w);
      default: ;
    endcase
    if (emit) begin
      out_q <= res_sat;
    end
  end

endmodule

// ===== design/smwlfo_checker.sv =====
// Port-level checker for the smoothed mixed-wave LFO, bound to the top level.
`include "smoothed_mixed_wave_lfo_macros.svh"

module smwlfo_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [smwlfo_pkg::DEPTH_W-1:0]    lfo_us_o,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o,
  input logic [smwlfo_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [smwlfo_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // last depth written through the config port
  logic [smwlfo_pkg::DEPTH_W-1:0] depth_seen_q;
  logic                           out_stall;
  logic                           in_take;

  assign out_stall = out_valid_o && !out_ready_i;
  assign in_take   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_seen_q <= smwlfo_pkg::DEPTH_US_RST;
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i == smwlfo_pkg::REG_DEPTH_US)) begin
      depth_seen_q <= cfg_data_i[smwlfo_pkg::DEPTH_W-1:0];
    end
  end

  `SMWLFO_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o, "word dropped in stall")
  `SMWLFO_ASSERT_NEXT(a_out_stable, out_stall, $stable(lfo_us_o), "word changed in stall")
  `SMWLFO_ASSERT_NEXT(a_one_in_flight, in_take, !in_ready_o, "second word taken in flight")
  `SMWLFO_ASSERT_NOW(a_within_depth, out_valid_o, lfo_us_o <= depth_seen_q, "word above depth")

endmodule

bind smoothed_mixed_wave_lfo smwlfo_checker u_smwlfo_checker (.*);
